// File: src/mer_pkg.sv
package mer_pkg;

    localparam int COORD_WIDTH_DEF = 12;
    localparam int AXIS_WIDTH_DEF  = 11;
    localparam int OUT_W           = 14;
    localparam int UPC_W           = 4;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef logic [UPC_W-1:0] t_upc;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_MUL_AA,
        OP_MUL_BB,
        OP_MUL_AAB,
        OP_INIT1,
        OP_ADV1,
        OP_ADV2,
        OP_MUL_TX,
        OP_MUL_TY,
        OP_MUL_BBT,
        OP_MUL_AAT,
        OP_INIT2,
        OP_EMIT,
        OP_EMPTY
    } t_op;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_JUMP,
        COND_DISPATCH,
        COND_SETTLE,
        COND_OUT_WAIT
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic fire;
    } t_dp_ctl;

    typedef struct packed {
        logic region_done;
        logic active;
        logic out_busy;
    } t_dp_stat;

    // microprogram addresses
    localparam t_upc U_IDLE    = 4'd0;
    localparam t_upc U_S_AA    = 4'd1;
    localparam t_upc U_S_BB    = 4'd2;
    localparam t_upc U_S_AAB   = 4'd3;
    localparam t_upc U_S_INIT  = 4'd4;
    localparam t_upc U_SETTLE  = 4'd5;
    localparam t_upc U_ADV1    = 4'd6;
    localparam t_upc U_ADV2    = 4'd7;
    localparam t_upc U_R_TX    = 4'd8;
    localparam t_upc U_R_TY    = 4'd9;
    localparam t_upc U_R_BBT   = 4'd10;
    localparam t_upc U_R_AAT   = 4'd11;
    localparam t_upc U_R_INIT  = 4'd12;
    localparam t_upc U_EMIT    = 4'd13;
    localparam t_upc U_EMPTY   = 4'd14;

    function automatic t_uword ucode(input t_upc upc);
        t_uword w;
        w = '{op: OP_NOP, cond: COND_JUMP, target: U_IDLE};
        case (upc)
            U_IDLE:   w = '{op: OP_LATCH,   cond: COND_DISPATCH, target: U_IDLE};
            U_S_AA:   w = '{op: OP_MUL_AA,  cond: COND_NEXT,     target: U_IDLE};
            U_S_BB:   w = '{op: OP_MUL_BB,  cond: COND_NEXT,     target: U_IDLE};
            U_S_AAB:  w = '{op: OP_MUL_AAB, cond: COND_NEXT,     target: U_IDLE};
            U_S_INIT: w = '{op: OP_INIT1,   cond: COND_NEXT,     target: U_IDLE};
            U_SETTLE: w = '{op: OP_NOP,     cond: COND_SETTLE,   target: U_R_TX};
            U_ADV1:   w = '{op: OP_ADV1,    cond: COND_NEXT,     target: U_IDLE};
            U_ADV2:   w = '{op: OP_ADV2,    cond: COND_SETTLE,   target: U_R_TX};
            U_R_TX:   w = '{op: OP_MUL_TX,  cond: COND_NEXT,     target: U_IDLE};
            U_R_TY:   w = '{op: OP_MUL_TY,  cond: COND_NEXT,     target: U_IDLE};
            U_R_BBT:  w = '{op: OP_MUL_BBT, cond: COND_NEXT,     target: U_IDLE};
            U_R_AAT:  w = '{op: OP_MUL_AAT, cond: COND_NEXT,     target: U_IDLE};
            U_R_INIT: w = '{op: OP_INIT2,   cond: COND_JUMP,     target: U_EMIT};
            U_EMIT:   w = '{op: OP_EMIT,    cond: COND_OUT_WAIT, target: U_IDLE};
            U_EMPTY:  w = '{op: OP_EMPTY,   cond: COND_OUT_WAIT, target: U_IDLE};
            default:  w = '{op: OP_NOP,     cond: COND_JUMP,     target: U_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: src/mer_seq.sv
module mer_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_command,
    input  mer_pkg::t_dp_stat  i_stat,
    output logic               o_stall,
    output mer_pkg::t_dp_ctl   o_ctl
);

    mer_pkg::t_upc   r_upc;
    mer_pkg::t_upc   n_upc;
    mer_pkg::t_uword w_word;
    logic            w_accept;

    assign w_word   = mer_pkg::ucode(r_upc);
    assign w_accept = i_valid && (w_word.cond == mer_pkg::COND_DISPATCH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= mer_pkg::U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    // next step
    always_comb begin
        n_upc = r_upc;
        case (w_word.cond)
            mer_pkg::COND_NEXT: begin
                n_upc = r_upc + mer_pkg::t_upc'(1);
            end
            mer_pkg::COND_JUMP: begin
                n_upc = w_word.target;
            end
            mer_pkg::COND_DISPATCH: begin
                if (!w_accept) begin
                    n_upc = r_upc;
                end else if (i_command == mer_pkg::CMD_START) begin
                    n_upc = mer_pkg::U_S_AA;
                end else if (i_stat.active) begin
                    n_upc = mer_pkg::U_ADV1;
                end else begin
                    n_upc = mer_pkg::U_EMPTY;
                end
            end
            mer_pkg::COND_SETTLE: begin
                n_upc = i_stat.region_done ? w_word.target : mer_pkg::U_EMIT;
            end
            mer_pkg::COND_OUT_WAIT: begin
                n_upc = i_stat.out_busy ? r_upc : w_word.target;
            end
            default: begin
                n_upc = mer_pkg::U_IDLE;
            end
        endcase
    end

    // control word to the datapath
    always_comb begin
        o_stall   = (w_word.cond != mer_pkg::COND_DISPATCH);
        o_ctl.op  = w_word.op;
        case (w_word.cond)
            mer_pkg::COND_DISPATCH: o_ctl.fire = w_accept;
            mer_pkg::COND_OUT_WAIT: o_ctl.fire = !i_stat.out_busy;
            default:                o_ctl.fire = 1'b1;
        endcase
    end

endmodule

// File: src/mer_dp.sv
module mer_dp #(
    parameter int COORD_WIDTH = mer_pkg::COORD_WIDTH_DEF,
    parameter int AXIS_WIDTH  = mer_pkg::AXIS_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mer_pkg::t_dp_ctl                  i_ctl,
    output mer_pkg::t_dp_stat                 o_stat,
    input  logic                              i_command,
    input  logic [COORD_WIDTH-1:0]            i_center_x,
    input  logic [COORD_WIDTH-1:0]            i_center_y,
    input  logic [AXIS_WIDTH-1:0]             i_semi_axis_a,
    input  logic [AXIS_WIDTH-1:0]             i_semi_axis_b,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic signed [mer_pkg::OUT_W-1:0]  o_col_right,
    output logic signed [mer_pkg::OUT_W-1:0]  o_col_left,
    output logic signed [mer_pkg::OUT_W-1:0]  o_row_low,
    output logic signed [mer_pkg::OUT_W-1:0]  o_row_high,
    output logic                              o_valid_res,
    output logic                              o_last
);

    localparam int OW  = AXIS_WIDTH + 2;
    localparam int TXW = OW + 1;
    localparam int AAW = 2 * AXIS_WIDTH;
    localparam int T1W = 2 * TXW;
    localparam int T2W = T1W + 1;
    localparam int MAW = AAW + 1;
    localparam int MBW = T2W;
    localparam int DW  = MAW + MBW;
    localparam int SW  = 3 * AXIS_WIDTH + 4;
    localparam int EXW = COORD_WIDTH + OW + mer_pkg::OUT_W;
    localparam int QW  = mer_pkg::OUT_W;

    logic [COORD_WIDTH-1:0] r_cx;
    logic [COORD_WIDTH-1:0] r_cy;
    logic [AXIS_WIDTH-1:0]  r_a;
    logic [AXIS_WIDTH-1:0]  r_b;
    logic [AAW-1:0]         r_aa;
    logic [AAW-1:0]         r_bb;
    logic [OW-1:0]          r_x;
    logic [OW-1:0]          r_y;
    logic [SW-1:0]          r_sx;
    logic [SW-1:0]          r_sy;
    logic signed [DW-1:0]   r_d;
    logic signed [DW-1:0]   r_prod;
    logic [T1W-1:0]         r_t1;
    logic signed [T2W-1:0]  r_t2;
    logic                   r_r2;
    logic                   r_took;
    logic                   r_active;
    logic                   r_out_valid;
    logic signed [QW-1:0]   r_col_right;
    logic signed [QW-1:0]   r_col_left;
    logic signed [QW-1:0]   r_row_low;
    logic signed [QW-1:0]   r_row_high;
    logic                   r_valid_res;
    logic                   r_last;

    logic [TXW-1:0]         w_tx;
    logic [OW-1:0]          w_ty;
    logic signed [MAW-1:0]  w_mul_a;
    logic signed [MBW-1:0]  w_mul_b;
    logic signed [DW-1:0]   w_prod;
    logic signed [DW-1:0]   e_aa;
    logic signed [DW-1:0]   e_bb;
    logic signed [DW-1:0]   e_sx;
    logic signed [DW-1:0]   e_sy;
    logic signed [DW-1:0]   w_n1;
    logic signed [DW-1:0]   w_n2;
    logic signed [DW-1:0]   w_d_adv;
    logic signed [T2W-1:0]  w_t2;
    logic [SW-1:0]          w_two_aa;
    logic [SW-1:0]          w_two_bb;
    logic                   w_d_neg;
    logic                   w_d_pos;
    logic                   w_more;
    logic                   w_load_out;
    logic [EXW-1:0]         w_cr;
    logic [EXW-1:0]         w_cl;
    logic [EXW-1:0]         w_rl;
    logic [EXW-1:0]         w_rh;

    // divide by four, rounding toward zero
    function automatic logic signed [DW-1:0] quarter(input logic signed [DW-1:0] n);
        logic signed [DW-1:0] s;
        s = n + (n[DW-1] ? DW'(3) : DW'(0));
        quarter = s >>> 2;
    endfunction

    assign w_tx = {r_x, 1'b1};
    assign w_ty = (r_y == '0) ? OW'(1) : (r_y - OW'(1));

    // shared multiplier operand selection
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_ctl.op)
            mer_pkg::OP_MUL_AA: begin
                w_mul_a = MAW'(r_a);
                w_mul_b = MBW'(r_a);
            end
            mer_pkg::OP_MUL_BB: begin
                w_mul_a = MAW'(r_b);
                w_mul_b = MBW'(r_b);
            end
            mer_pkg::OP_MUL_AAB: begin
                w_mul_a = MAW'(r_aa);
                w_mul_b = MBW'(r_b);
            end
            mer_pkg::OP_MUL_TX: begin
                w_mul_a = MAW'(w_tx);
                w_mul_b = MBW'(w_tx);
            end
            mer_pkg::OP_MUL_TY: begin
                w_mul_a = MAW'(w_ty);
                w_mul_b = MBW'(w_ty);
            end
            mer_pkg::OP_MUL_BBT: begin
                w_mul_a = MAW'(r_bb);
                w_mul_b = MBW'(r_t1);
            end
            mer_pkg::OP_MUL_AAT: begin
                w_mul_a = MAW'(r_aa);
                w_mul_b = r_t2;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    assign e_aa = DW'(r_aa);
    assign e_bb = DW'(r_bb);
    assign e_sx = DW'(r_sx);
    assign e_sy = DW'(r_sy);

    assign w_two_aa = SW'({r_aa, 1'b0});
    assign w_two_bb = SW'({r_bb, 1'b0});

    // region one start value, r_prod holds aa*b
    assign w_n1 = (e_bb <<< 2) + e_aa - (r_prod <<< 2) + DW'(2);
    // region two start value, r_d holds bb*(2x+1)^2 and r_prod aa*(4(y-1)^2-4bb)
    assign w_n2 = r_d + r_prod + DW'(2);
    // r_prod holds (y-1)^2
    assign w_t2 = (T2W'(r_prod[T1W-3:0]) <<< 2) - (T2W'(r_bb) <<< 2);

    assign w_d_neg = r_d[DW-1];
    assign w_d_pos = !r_d[DW-1] && (r_d != '0);

    always_comb begin
        if (r_r2) begin
            w_d_adv = r_d + e_aa - e_sy + (r_took ? e_sx : DW'(0));
        end else begin
            w_d_adv = r_d + e_bb + e_sx - (r_took ? e_sy : DW'(0));
        end
    end

    assign w_more = r_r2 ? (r_y != '0) : 1'b1;

    assign w_cr = EXW'(r_cx) + EXW'(r_x);
    assign w_cl = EXW'(r_cx) - EXW'(r_x);
    assign w_rl = EXW'(r_cy) + EXW'(r_y);
    assign w_rh = EXW'(r_cy) - EXW'(r_y);

    assign w_load_out = i_ctl.fire &&
                        ((i_ctl.op == mer_pkg::OP_EMIT) || (i_ctl.op == mer_pkg::OP_EMPTY));

    always_ff @(posedge i_clk) begin
        if (i_ctl.fire) begin
            case (i_ctl.op)
                mer_pkg::OP_LATCH: begin
                    if (i_command == mer_pkg::CMD_START) begin
                        r_cx <= i_center_x;
                        r_cy <= i_center_y;
                        r_a  <= i_semi_axis_a;
                        r_b  <= i_semi_axis_b;
                    end
                end
                mer_pkg::OP_MUL_AA: begin
                    r_prod <= w_prod;
                end
                mer_pkg::OP_MUL_BB: begin
                    r_aa   <= r_prod[AAW-1:0];
                    r_prod <= w_prod;
                end
                mer_pkg::OP_MUL_AAB: begin
                    r_bb   <= r_prod[AAW-1:0];
                    r_prod <= w_prod;
                end
                mer_pkg::OP_INIT1: begin
                    r_sy <= SW'(r_prod <<< 1);
                    r_d  <= quarter(w_n1);
                    r_x  <= '0;
                    r_y  <= OW'(r_b);
                    r_sx <= '0;
                    r_r2 <= 1'b0;
                end
                mer_pkg::OP_ADV1: begin
                    if (!r_r2) begin
                        r_x    <= r_x + OW'(1);
                        r_sx   <= r_sx + w_two_bb;
                        r_took <= !w_d_neg;
                        if (!w_d_neg) begin
                            r_sy <= r_sy - w_two_aa;
                            r_y  <= r_y - OW'(1);
                        end
                    end else begin
                        r_y    <= r_y - OW'(1);
                        r_sy   <= r_sy - w_two_aa;
                        r_took <= !w_d_pos;
                        if (!w_d_pos) begin
                            r_sx <= r_sx + w_two_bb;
                            r_x  <= r_x + OW'(1);
                        end
                    end
                end
                mer_pkg::OP_ADV2: begin
                    r_d <= w_d_adv;
                end
                mer_pkg::OP_MUL_TX: begin
                    r_prod <= w_prod;
                end
                mer_pkg::OP_MUL_TY: begin
                    r_t1   <= r_prod[T1W-1:0];
                    r_prod <= w_prod;
                end
                mer_pkg::OP_MUL_BBT: begin
                    r_t2   <= w_t2;
                    r_prod <= w_prod;
                end
                mer_pkg::OP_MUL_AAT: begin
                    r_d    <= r_prod;
                    r_prod <= w_prod;
                end
                mer_pkg::OP_INIT2: begin
                    r_d  <= quarter(w_n2);
                    r_r2 <= 1'b1;
                end
                mer_pkg::OP_EMIT: begin
                    r_col_right <= w_cr[QW-1:0];
                    r_col_left  <= w_cl[QW-1:0];
                    r_row_low   <= w_rl[QW-1:0];
                    r_row_high  <= w_rh[QW-1:0];
                    r_valid_res <= 1'b1;
                    r_last      <= !w_more;
                end
                mer_pkg::OP_EMPTY: begin
                    r_col_right <= '0;
                    r_col_left  <= '0;
                    r_row_low   <= '0;
                    r_row_high  <= '0;
                    r_valid_res <= 1'b0;
                    r_last      <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.fire && (i_ctl.op == mer_pkg::OP_EMIT)) begin
                r_active <= w_more;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.region_done = !r_r2 && !(r_sx < r_sy);
    assign o_stat.active      = r_active;
    assign o_stat.out_busy    = r_out_valid && i_stall;

    assign o_valid     = r_out_valid;
    assign o_col_right = r_col_right;
    assign o_col_left  = r_col_left;
    assign o_row_low   = r_row_low;
    assign o_row_high  = r_row_high;
    assign o_valid_res = r_valid_res;
    assign o_last      = r_last;

endmodule

// File: src/midpoint_ellipse_rasterizer.sv
// start: aa, bb and aa*b pass through the shared multiplier, then the decision
// value is formed; step: x and y advance, then the decision value is updated;
// the region change adds four passes through the shared multiplier and the new
// decision value; a step with no ellipse in progress gives an empty result; a new
// transaction waits until the result is loaded; reset (i_rst_n low, synchronous)
// clears the step counter, the output valid and the ellipse-active flag
module midpoint_ellipse_rasterizer #(
    parameter int COORD_WIDTH = mer_pkg::COORD_WIDTH_DEF,
    parameter int AXIS_WIDTH  = mer_pkg::AXIS_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_command,
    input  logic [COORD_WIDTH-1:0]            i_center_x,
    input  logic [COORD_WIDTH-1:0]            i_center_y,
    input  logic [AXIS_WIDTH-1:0]             i_semi_axis_a,
    input  logic [AXIS_WIDTH-1:0]             i_semi_axis_b,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [mer_pkg::OUT_W-1:0]  o_col_right,
    output logic signed [mer_pkg::OUT_W-1:0]  o_col_left,
    output logic signed [mer_pkg::OUT_W-1:0]  o_row_low,
    output logic signed [mer_pkg::OUT_W-1:0]  o_row_high,
    output logic                              o_valid_res,
    output logic                              o_last
);

    mer_pkg::t_dp_ctl  w_ctl;
    mer_pkg::t_dp_stat w_stat;

    mer_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_stat    (w_stat),
        .o_stall   (o_stall),
        .o_ctl     (w_ctl)
    );

    mer_dp #(
        .COORD_WIDTH (COORD_WIDTH),
        .AXIS_WIDTH  (AXIS_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .o_stat        (w_stat),
        .i_command     (i_command),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_semi_axis_a (i_semi_axis_a),
        .i_semi_axis_b (i_semi_axis_b),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_col_right   (o_col_right),
        .o_col_left    (o_col_left),
        .o_row_low     (o_row_low),
        .o_row_high    (o_row_high),
        .o_valid_res   (o_valid_res),
        .o_last        (o_last)
    );

endmodule
